FILE: rtl/core/hssp_pkg.sv
// ----------------------------------------------------------------------------
// hssp_pkg: shared types and constants for the height slope shade core
// Transaction structs, fixed-point widths and the divider reciprocal table.
// ----------------------------------------------------------------------------
package hssp_pkg;

    // Fixed-point format of the heights and of the shade factor
    localparam int FRAC_BITS = 12;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int F_W       = FRAC_BITS + 1;   // shade factor holds 0..ONE

    // Window geometry
    localparam int CELLS      = 9;
    localparam int CENTER_IDX = 4;
    localparam int H_W        = 16;             // height width
    localparam int DIFF_W     = 16;             // |hc - hq| is at most 65535
    localparam int GRP_W      = DIFF_W + 2;     // sum of three differences
    localparam int SUM_W      = DIFF_W + 3;     // sum over the window
    localparam int CNT_W      = 4;              // 0..9 present cells
    localparam int RECIP_W    = SUM_W + 1;      // reciprocal of count, SUM_W fraction bits
    localparam int MEAN_W     = SUM_W;

    // Depth tint gains and output scaling
    localparam int TINT_G_GAIN = 200;
    localparam int TINT_B_GAIN = 100;
    localparam int SHADE_GAIN  = 255;
    localparam int TINT_W      = 8;
    localparam int GAIN_W      = 8;
    localparam int MAG_W       = H_W + 1;
    localparam int TPROD_W     = MAG_W + GAIN_W;

    // Divide by three over 0..765: multiply by ceil(2^11 / 3) and shift
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int RGB_SUM_W  = 10;
    localparam int DIV3_W     = RGB_SUM_W + DIV3_SHIFT;

    // Pipeline depth from accepted start to done
    localparam int LATENCY = 8;

    typedef struct packed {
        logic [8:0]             present_mask;
        logic signed [H_W-1:0]  h_nw;
        logic signed [H_W-1:0]  h_n;
        logic signed [H_W-1:0]  h_ne;
        logic signed [H_W-1:0]  h_w;
        logic signed [H_W-1:0]  h_c;
        logic signed [H_W-1:0]  h_e;
        logic signed [H_W-1:0]  h_sw;
        logic signed [H_W-1:0]  h_s;
        logic signed [H_W-1:0]  h_se;
    } item_t;

    typedef struct packed {
        logic [7:0] gray;
        logic       written;
    } result_t;

    // Per-transaction control that rides alongside the datapath
    typedef struct packed {
        logic              valid;
        logic              written;
        logic [TINT_W-1:0] tg;
        logic [TINT_W-1:0] tb;
    } side_t;

    // floor(2^SUM_W / c): the quotient estimate is exact or one low
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
        logic [RECIP_W-1:0] r;
        unique case (c)
            4'd1:    r = RECIP_W'((1 << SUM_W) / 1);
            4'd2:    r = RECIP_W'((1 << SUM_W) / 2);
            4'd3:    r = RECIP_W'((1 << SUM_W) / 3);
            4'd4:    r = RECIP_W'((1 << SUM_W) / 4);
            4'd5:    r = RECIP_W'((1 << SUM_W) / 5);
            4'd6:    r = RECIP_W'((1 << SUM_W) / 6);
            4'd7:    r = RECIP_W'((1 << SUM_W) / 7);
            4'd8:    r = RECIP_W'((1 << SUM_W) / 8);
            4'd9:    r = RECIP_W'((1 << SUM_W) / 9);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/hssp_lane.sv
// ----------------------------------------------------------------------------
// hssp_lane: one window cell
// Registers the absolute height difference to the center, zero when absent.
// ----------------------------------------------------------------------------
module hssp_lane
    import hssp_pkg::*;
(
    input  logic                  clk,
    input  logic signed [H_W-1:0] hc,
    input  logic signed [H_W-1:0] hq,
    input  logic                  present,
    output logic [DIFF_W-1:0]     diff
);

    logic signed [H_W:0] delta;
    logic signed [H_W:0] mag;
    logic [DIFF_W-1:0]   diff_reg;
    logic [DIFF_W-1:0]   diff_next;

    // Form |hc - hq| at full precision, drop absent cells
    always_comb
    begin
        delta     = $signed({hc[H_W-1], hc}) - $signed({hq[H_W-1], hq});
        mag       = delta[H_W] ? -delta : delta;
        diff_next = present ? mag[DIFF_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
    end

    assign diff = diff_reg;

endmodule

FILE: rtl/core/hssp_merge.sv
// ----------------------------------------------------------------------------
// hssp_merge: lane merge tree
// Sums the nine lane differences in two registered levels.
// ----------------------------------------------------------------------------
module hssp_merge
    import hssp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [DIFF_W-1:0]       diff [CELLS],
    input  logic [CNT_W-1:0]        cnt_in,
    input  side_t                   side_in,
    output logic [SUM_W-1:0]        sum,
    output logic [CNT_W-1:0]        cnt_out,
    output side_t                   side_out
);

    logic [GRP_W-1:0] grp_reg  [3];
    logic [GRP_W-1:0] grp_next [3];
    logic [CNT_W-1:0] cnt_a_reg;
    side_t            side_a_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] cnt_b_reg;
    side_t            side_b_reg;

    // First level: one partial sum per window row
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            grp_next[i] = GRP_W'(diff[3*i]) + GRP_W'(diff[3*i+1]) + GRP_W'(diff[3*i+2]);
        end
    end

    // Second level: total over the window (center lane is zero)
    always_comb
    begin
        sum_next = SUM_W'(grp_reg[0]) + SUM_W'(grp_reg[1]) + SUM_W'(grp_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        grp_reg   <= grp_next;
        cnt_a_reg <= cnt_in;
        sum_reg   <= sum_next;
        cnt_b_reg <= cnt_a_reg;
    end

    // Advance the transaction side data; clear the valid flags on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
            side_b_reg <= '0;
        end
        else
        begin
            side_a_reg <= side_in;
            side_b_reg <= side_a_reg;
        end
    end

    assign sum      = sum_reg;
    assign cnt_out  = cnt_b_reg;
    assign side_out = side_b_reg;

endmodule

FILE: rtl/core/hssp_div.sv
// ----------------------------------------------------------------------------
// hssp_div: mean of the window differences
// Divides the sum by the cell count (1..9) through a reciprocal multiply
// and a single correction step.
// ----------------------------------------------------------------------------
module hssp_div
    import hssp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SUM_W-1:0]   sum,
    input  logic [CNT_W-1:0]   cnt,
    input  side_t              side_in,
    output logic [MEAN_W-1:0]  mean,
    output side_t              side_out
);

    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int BACK_W = SUM_W + CNT_W;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  q0_reg;
    logic [SUM_W-1:0]  q0_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    side_t             side_a_reg;
    logic [BACK_W-1:0] back;
    logic [BACK_W-1:0] rem;
    logic [MEAN_W-1:0] mean_reg;
    logic [MEAN_W-1:0] mean_next;
    side_t             side_b_reg;

    // Quotient estimate: floor(sum * recip / 2^SUM_W), exact or one low
    always_comb
    begin
        prod    = PROD_W'(sum) * PROD_W'(recip(cnt));
        q0_next = prod[SUM_W +: SUM_W];
    end

    // Correct the estimate from the remainder
    always_comb
    begin
        back = BACK_W'(q0_reg) * BACK_W'(cnt_reg);
        rem  = BACK_W'(sum_reg) - back;
        if (rem >= BACK_W'(cnt_reg))
        begin
            mean_next = MEAN_W'(q0_reg) + MEAN_W'(1);
        end
        else
        begin
            mean_next = MEAN_W'(q0_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg   <= q0_next;
        sum_reg  <= sum;
        cnt_reg  <= cnt;
        mean_reg <= mean_next;
    end

    // Advance the transaction side data; clear the valid flags on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
            side_b_reg <= '0;
        end
        else
        begin
            side_a_reg <= side_in;
            side_b_reg <= side_a_reg;
        end
    end

    assign mean     = mean_reg;
    assign side_out = side_b_reg;

endmodule

FILE: rtl/core/hssp_shade.sv
// ----------------------------------------------------------------------------
// hssp_shade: shade factor and gray level
// Turns the mean slope into the shade factor, scales the red level and the
// depth tints by it, and averages the three channels to one gray level.
// ----------------------------------------------------------------------------
module hssp_shade
    import hssp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MEAN_W-1:0] mean,
    input  side_t             side_in,
    output result_t           result,
    output logic              done
);

    localparam int CMP_W  = MEAN_W + 2;
    localparam int CPROD_W = F_W + GAIN_W;

    logic [CMP_W-1:0]   twice;
    logic [F_W-1:0]     f_reg;
    logic [F_W-1:0]     f_next;
    side_t              side_a_reg;
    logic [CPROD_W-1:0] r_prod;
    logic [CPROD_W-1:0] g_prod;
    logic [CPROD_W-1:0] b_prod;
    logic [7:0]         r_reg;
    logic [7:0]         g_reg;
    logic [7:0]         b_reg;
    logic               written_b_reg;
    logic               valid_b_reg;
    logic [RGB_SUM_W-1:0] rgb_sum;
    logic [DIV3_W-1:0]  div3_prod;
    logic [7:0]         gray_next;
    result_t            result_reg;
    logic               done_reg;

    // f = ONE - min(2 * mean, ONE)
    always_comb
    begin
        twice = {1'b0, mean, 1'b0};
        if (twice >= CMP_W'(ONE))
        begin
            f_next = '0;
        end
        else
        begin
            f_next = F_W'(CMP_W'(ONE) - twice);
        end
    end

    // Scale each channel by the shade factor
    always_comb
    begin
        r_prod = CPROD_W'(SHADE_GAIN) * CPROD_W'(f_reg);
        g_prod = CPROD_W'(side_a_reg.tg) * CPROD_W'(f_reg);
        b_prod = CPROD_W'(side_a_reg.tb) * CPROD_W'(f_reg);
    end

    // Average the channels; absent center forces black
    always_comb
    begin
        rgb_sum   = RGB_SUM_W'(r_reg) + RGB_SUM_W'(g_reg) + RGB_SUM_W'(b_reg);
        div3_prod = DIV3_W'(rgb_sum) * DIV3_W'(DIV3_MUL);
        gray_next = written_b_reg ? div3_prod[DIV3_SHIFT +: 8] : '0;
    end

    always_ff @(posedge clk)
    begin
        f_reg              <= f_next;
        r_reg              <= r_prod[FRAC_BITS +: 8];
        g_reg              <= g_prod[FRAC_BITS +: 8];
        b_reg              <= b_prod[FRAC_BITS +: 8];
        written_b_reg      <= side_a_reg.written;
        result_reg.gray    <= gray_next;
        result_reg.written <= written_b_reg;
    end

    // Advance the transaction side data; clear the valid flags on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg  <= '0;
            valid_b_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            side_a_reg  <= side_in;
            valid_b_reg <= side_a_reg.valid;
            done_reg    <= valid_b_reg;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

FILE: rtl/core/height_slope_shade_pixel_core.sv
// ----------------------------------------------------------------------------
// height_slope_shade_pixel_core: slope and depth shading of one grid pixel
// Nine cell lanes, a merge tree, a count divider and a shading back end.
// ----------------------------------------------------------------------------
// Usage: the core takes one 3x3 window per clock. busy is always low, so a
// transaction is accepted on every cycle that start is high, and its result
// appears on result with done high, for one cycle
// only. The receiver cannot hold results off; it must take result whenever
// done is high. The 8-stage pipeline is set by the lane stage, two merge tree
// levels, the two-step reciprocal divider and the three shading stages.
// ----------------------------------------------------------------------------
module height_slope_shade_pixel_core
    import hssp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    logic signed [H_W-1:0] cell_h [CELLS];
    logic [DIFF_W-1:0]     diff   [CELLS];
    logic                  accept;
    logic [MAG_W-1:0]      mag;
    logic [TPROD_W-1:0]    tg_prod;
    logic [TPROD_W-1:0]    tb_prod;
    logic [TPROD_W-1:0]    tg_q;
    logic [TPROD_W-1:0]    tb_q;
    side_t                 side_next;
    side_t                 side1_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [SUM_W-1:0]      sum;
    logic [CNT_W-1:0]      cnt_m;
    side_t                 side_m;
    logic [MEAN_W-1:0]     mean;
    side_t                 side_d;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Window cells in mask bit order
    assign cell_h[0] = item.h_nw;
    assign cell_h[1] = item.h_n;
    assign cell_h[2] = item.h_ne;
    assign cell_h[3] = item.h_w;
    assign cell_h[4] = item.h_c;
    assign cell_h[5] = item.h_e;
    assign cell_h[6] = item.h_sw;
    assign cell_h[7] = item.h_s;
    assign cell_h[8] = item.h_se;

    // One lane per window cell
    for (genvar i = 0; i < CELLS; i++)
    begin : g_lane
        hssp_lane u_lane (
            .clk     (clk),
            .hc      (item.h_c),
            .hq      (cell_h[i]),
            .present (item.present_mask[i]),
            .diff    (diff[i])
        );
    end

    // Depth tints from the center height, and the present cell count
    always_comb
    begin
        mag     = item.h_c[H_W-1] ? MAG_W'(-$signed({item.h_c[H_W-1], item.h_c})) : '0;
        tg_prod = TPROD_W'(mag) * TPROD_W'(TINT_G_GAIN);
        tb_prod = TPROD_W'(mag) * TPROD_W'(TINT_B_GAIN);
        tg_q    = tg_prod >> FRAC_BITS;
        tb_q    = tb_prod >> FRAC_BITS;
        side_next.valid   = accept;
        side_next.written = item.present_mask[CENTER_IDX];
        side_next.tg      = (tg_q > TPROD_W'(255)) ? 8'hFF : tg_q[TINT_W-1:0];
        side_next.tb      = (tb_q > TPROD_W'(255)) ? 8'hFF : tb_q[TINT_W-1:0];
        cnt_next          = CNT_W'($countones(item.present_mask));
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
    end

    // Hold the side data of the lane stage; clear the valid flag on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
        end
        else
        begin
            side1_reg <= side_next;
        end
    end

    hssp_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .diff     (diff),
        .cnt_in   (cnt_reg),
        .side_in  (side1_reg),
        .sum      (sum),
        .cnt_out  (cnt_m),
        .side_out (side_m)
    );

    hssp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .sum      (sum),
        .cnt      (cnt_m),
        .side_in  (side_m),
        .mean     (mean),
        .side_out (side_d)
    );

    hssp_shade u_shade (
        .clk     (clk),
        .rst_n   (rst_n),
        .mean    (mean),
        .side_in (side_d),
        .result  (result),
        .done    (done)
    );

    // Every accepted transaction yields done
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted transaction produced no result");

    // No result without a matching accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a transaction");

    // written follows the center presence bit of the same transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.written == $past(item.present_mask[CENTER_IDX], LATENCY))
        else $error("written does not match center presence");

    // Absent center gives black
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.written |-> result.gray == 8'd0)
        else $error("gray nonzero for unwritten pixel");

endmodule
